// File: design/segment_pair_closest_points_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the segment pair closest points unit
// Concurrent checks sampled on the rising clock edge, idle during reset.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_PAIR_CLOSEST_POINTS_UNIT_DEFINES_SVH
`define SEGMENT_PAIR_CLOSEST_POINTS_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPCP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SPCP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/spcp_pkg.sv
// ----------------------------------------------------------------------------
// spcp_pkg
// Shared constants for the segment pair closest points unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package spcp_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS       = 16;
  localparam int Q_W             = FRAC_BITS + 1;
  localparam int THR_W           = 32;

  // Segment parameter 1.0 in unsigned Q1.16.
  localparam logic [Q_W-1:0] Q_ONE = {1'b1, {FRAC_BITS{1'b0}}};

  localparam logic [THR_W-1:0] DEG_THR_RESET = 32'd4295;

endpackage

`default_nettype wire

// File: design/spcp_mul_split.sv
// ----------------------------------------------------------------------------
// spcp_mul_split
// Two-stage signed multiplier built from four half-width partial products.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spcp_mul_split #(
  parameter int A_W = 68
) (
  input  wire logic                    clk,
  input  wire logic                    en,
  input  wire logic signed [A_W-1:0]   a,
  input  wire logic signed [A_W-1:0]   b,
  output logic signed [2*A_W-1:0]      p
);

  localparam int LO_W = A_W / 2;
  localparam int HI_W = A_W - LO_W;
  localparam int PW   = 2 * A_W;

  logic signed [HI_W-1:0]        a_hi, b_hi;
  logic        [LO_W-1:0]        a_lo, b_lo;
  logic signed [2*HI_W-1:0]      pp_hh_r;
  logic signed [HI_W+LO_W:0]     pp_hl_r, pp_lh_r;
  logic        [2*LO_W-1:0]      pp_ll_r;
  logic signed [PW-1:0]          p_r;

  assign a_hi = a[A_W-1:LO_W];
  assign b_hi = b[A_W-1:LO_W];
  assign a_lo = a[LO_W-1:0];
  assign b_lo = b[LO_W-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      pp_hh_r <= a_hi * b_hi;
      pp_hl_r <= a_hi * $signed({1'b0, b_lo});
      pp_lh_r <= $signed({1'b0, a_lo}) * b_hi;
      pp_ll_r <= a_lo * b_lo;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= (PW'(pp_hh_r) <<< (2 * LO_W)) + (PW'(pp_hl_r) <<< LO_W) +
             (PW'(pp_lh_r) <<< LO_W) + PW'($signed({1'b0, pp_ll_r}));
    end
  end

  assign p = p_r;

endmodule

`default_nettype wire

// File: design/spcp_div_pipe.sv
// ----------------------------------------------------------------------------
// spcp_div_pipe
// Pipelined clamped ratio num/den in unsigned Q1.16, one quotient bit a stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spcp_div_pipe #(
  parameter int NUM_W  = 137,
  parameter int SIDE_W = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          en,
  input  wire logic                          in_valid,
  input  wire logic signed [NUM_W-1:0]       in_num,
  input  wire logic signed [NUM_W-1:0]       in_den,
  input  wire logic        [SIDE_W-1:0]      in_side,
  output logic                               out_valid,
  output logic        [spcp_pkg::Q_W-1:0]    out_quot,
  output logic        [SIDE_W-1:0]           out_side
);

  import spcp_pkg::*;

  localparam int STEPS = FRAC_BITS;

  logic                 v_r    [0:STEPS];
  logic [NUM_W-2:0]     rem_r  [0:STEPS];
  logic [NUM_W-2:0]     den_r  [0:STEPS];
  logic [FRAC_BITS-1:0] q_r    [0:STEPS];
  logic                 zero_r [0:STEPS];
  logic                 one_r  [0:STEPS];
  logic [SIDE_W-1:0]    side_r [0:STEPS];

  // Entry stage: numerator at or below zero gives 0, at or above den gives 1.0.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= in_num[NUM_W-2:0];
      den_r[0]  <= in_den[NUM_W-2:0];
      q_r[0]    <= '0;
      zero_r[0] <= in_num[NUM_W-1] || (in_num == '0);
      one_r[0]  <= (in_num >= in_den);
      side_r[0] <= in_side;
    end
  end

  for (genvar k = 1; k <= STEPS; k++) begin : g_step
    logic [NUM_W-1:0] dbl;
    logic [NUM_W-1:0] diff;
    logic             ge;

    assign dbl  = {rem_r[k-1], 1'b0};
    assign diff = dbl - {1'b0, den_r[k-1]};
    assign ge   = (dbl >= {1'b0, den_r[k-1]});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? diff[NUM_W-2:0] : dbl[NUM_W-2:0];
        den_r[k]  <= den_r[k-1];
        q_r[k]    <= {q_r[k-1][FRAC_BITS-2:0], ge};
        zero_r[k] <= zero_r[k-1];
        one_r[k]  <= one_r[k-1];
        side_r[k] <= side_r[k-1];
      end
    end
  end

  always_comb begin
    priority if (zero_r[STEPS]) begin
      out_quot = '0;
    end else if (one_r[STEPS]) begin
      out_quot = Q_ONE;
    end else begin
      out_quot = {1'b0, q_r[STEPS]};
    end
  end

  assign out_valid = v_r[STEPS];
  assign out_side  = side_r[STEPS];

endmodule

`default_nettype wire

// File: design/segment_pair_closest_points_unit.sv
// ----------------------------------------------------------------------------
// segment_pair_closest_points_unit
// Closest points between two 3D segments in signed Q16.16.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall with the start and end points of segments
// A and B. Result channel: out_valid / out_stall with the closest point on A
// and on B, saturated to the coordinate range. Configuration: cfg_valid /
// cfg_ready write the degenerate length threshold; cfg_ready is always high.
// Throughput is one item per cycle while the pipeline is not frozen. A result
// shows on out_valid after its item passes through the two 17-stage ratio
// dividers, the split wide multipliers and the point stages in series.
// Reset clears every valid bit and loads the threshold with 4295.
// When the receiver stalls with a result waiting and the last stage also
// holds an item, the whole pipeline freezes and in_stall rises; while the
// last stage is empty, items keep entering and bubbles are filled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "segment_pair_closest_points_unit_defines.svh"

module segment_pair_closest_points_unit #(
  parameter int COORD_WIDTH = spcp_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic signed [COORD_WIDTH-1:0]    in_a_start_x,
  input  wire logic signed [COORD_WIDTH-1:0]    in_a_start_y,
  input  wire logic signed [COORD_WIDTH-1:0]    in_a_start_z,
  input  wire logic signed [COORD_WIDTH-1:0]    in_a_end_x,
  input  wire logic signed [COORD_WIDTH-1:0]    in_a_end_y,
  input  wire logic signed [COORD_WIDTH-1:0]    in_a_end_z,
  input  wire logic signed [COORD_WIDTH-1:0]    in_b_start_x,
  input  wire logic signed [COORD_WIDTH-1:0]    in_b_start_y,
  input  wire logic signed [COORD_WIDTH-1:0]    in_b_start_z,
  input  wire logic signed [COORD_WIDTH-1:0]    in_b_end_x,
  input  wire logic signed [COORD_WIDTH-1:0]    in_b_end_y,
  input  wire logic signed [COORD_WIDTH-1:0]    in_b_end_z,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic signed [COORD_WIDTH-1:0]         out_near_a_x,
  output logic signed [COORD_WIDTH-1:0]         out_near_a_y,
  output logic signed [COORD_WIDTH-1:0]         out_near_a_z,
  output logic signed [COORD_WIDTH-1:0]         out_near_b_x,
  output logic signed [COORD_WIDTH-1:0]         out_near_b_y,
  output logic signed [COORD_WIDTH-1:0]         out_near_b_z,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [spcp_pkg::THR_W-1:0]       cfg_degenerate_threshold
);

  import spcp_pkg::*;

  localparam int DIFF_W = COORD_WIDTH + 1;
  localparam int DOT_W  = 2 * COORD_WIDTH + 4;
  localparam int PROD_W = 2 * DOT_W;
  localparam int NUM1_W = PROD_W + 1;
  localparam int NUM2_W = DOT_W + FRAC_BITS + 3;
  localparam int TP_W   = DOT_W + Q_W + 1;
  localparam int PT_W   = DIFF_W + Q_W + 1;
  localparam int SUM_W  = PT_W - FRAC_BITS + 1;

  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'({(COORD_WIDTH-1){1'b1}});
  localparam logic signed [SUM_W-1:0] SAT_LO = ~SAT_HI;

  typedef struct packed {
    logic [2:0][COORD_WIDTH-1:0] a0;
    logic [2:0][COORD_WIDTH-1:0] b0;
    logic [2:0][DIFF_W-1:0]      d1;
    logic [2:0][DIFF_W-1:0]      d2;
  } geo_t;

  typedef struct packed {
    geo_t             g;
    logic [DOT_W-1:0] bb;
    logic [DOT_W-1:0] e;
    logic [DOT_W-1:0] f;
    logic [DOT_W-1:0] c;
    logic [DOT_W-1:0] d;
    logic             adeg;
    logic             bdeg;
  } dot_side_t;

  typedef struct packed {
    geo_t           g;
    logic [Q_W-1:0] fixed;
    logic           q_to_t;
  } par_side_t;

  localparam int DOT_SIDE_W = $bits(dot_side_t);
  localparam int PAR_SIDE_W = $bits(par_side_t);

  // Pipeline control.
  logic en;
  logic out_free;
  logic out_valid_r;
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r, v8_r, v9_r, v10_r, v11_r;

  logic [THR_W-1:0] thr_r;

  assign out_free  = !out_valid_r || !out_stall;
  assign en        = out_free || !v11_r;
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= DEG_THR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      thr_r <= cfg_degenerate_threshold;
    end
  end

  // Stage 1: directions and start offset.
  logic [2:0][COORD_WIDTH-1:0] pa0, pa1, pb0, pb1;
  geo_t                         g1_nxt, g1_r;
  logic [2:0][DIFF_W-1:0]       r1_nxt, r1_r;

  assign pa0 = {in_a_start_z, in_a_start_y, in_a_start_x};
  assign pa1 = {in_a_end_z,   in_a_end_y,   in_a_end_x};
  assign pb0 = {in_b_start_z, in_b_start_y, in_b_start_x};
  assign pb1 = {in_b_end_z,   in_b_end_y,   in_b_end_x};

  always_comb begin
    g1_nxt.a0 = pa0;
    g1_nxt.b0 = pb0;
    for (int i = 0; i < 3; i++) begin
      g1_nxt.d1[i] = DIFF_W'($signed(pa1[i])) - DIFF_W'($signed(pa0[i]));
      g1_nxt.d2[i] = DIFF_W'($signed(pb1[i])) - DIFF_W'($signed(pb0[i]));
      r1_nxt[i]    = DIFF_W'($signed(pa0[i])) - DIFF_W'($signed(pb0[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g1_r <= g1_nxt;
      r1_r <= r1_nxt;
    end
  end

  // Stage 2: component products.
  geo_t                        g2_r;
  logic signed [2*DIFF_W-1:0]  pbb_r [3];
  logic signed [2*DIFF_W-1:0]  pe_r  [3];
  logic signed [2*DIFF_W-1:0]  pf_r  [3];
  logic signed [2*DIFF_W-1:0]  pc_r  [3];
  logic signed [2*DIFF_W-1:0]  pd_r  [3];

  always_ff @(posedge clk) begin
    if (en) begin
      g2_r <= g1_r;
      for (int i = 0; i < 3; i++) begin
        pbb_r[i] <= $signed(g1_r.d1[i]) * $signed(g1_r.d1[i]);
        pe_r[i]  <= $signed(g1_r.d2[i]) * $signed(g1_r.d2[i]);
        pf_r[i]  <= $signed(g1_r.d2[i]) * $signed(r1_r[i]);
        pc_r[i]  <= $signed(g1_r.d1[i]) * $signed(r1_r[i]);
        pd_r[i]  <= $signed(g1_r.d1[i]) * $signed(g1_r.d2[i]);
      end
    end
  end

  // Stage 3: dot products.
  dot_side_t s3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_r.g    <= g2_r;
      s3_r.bb   <= DOT_W'(pbb_r[0]) + DOT_W'(pbb_r[1]) + DOT_W'(pbb_r[2]);
      s3_r.e    <= DOT_W'(pe_r[0]) + DOT_W'(pe_r[1]) + DOT_W'(pe_r[2]);
      s3_r.f    <= DOT_W'(pf_r[0]) + DOT_W'(pf_r[1]) + DOT_W'(pf_r[2]);
      s3_r.c    <= DOT_W'(pc_r[0]) + DOT_W'(pc_r[1]) + DOT_W'(pc_r[2]);
      s3_r.d    <= DOT_W'(pd_r[0]) + DOT_W'(pd_r[1]) + DOT_W'(pd_r[2]);
      s3_r.adeg <= 1'b0;
      s3_r.bdeg <= 1'b0;
    end
  end

  // Stages 4 and 5: wide products, degenerate flags.
  dot_side_t            s4_nxt, s4_r, s5_r;
  logic signed [PROD_W-1:0] p_bbe, p_dd, p_df, p_ce;

  spcp_mul_split #(.A_W(DOT_W)) u_mul_bbe (
    .clk(clk), .en(en), .a($signed(s3_r.bb)), .b($signed(s3_r.e)), .p(p_bbe)
  );
  spcp_mul_split #(.A_W(DOT_W)) u_mul_dd (
    .clk(clk), .en(en), .a($signed(s3_r.d)), .b($signed(s3_r.d)), .p(p_dd)
  );
  spcp_mul_split #(.A_W(DOT_W)) u_mul_df (
    .clk(clk), .en(en), .a($signed(s3_r.d)), .b($signed(s3_r.f)), .p(p_df)
  );
  spcp_mul_split #(.A_W(DOT_W)) u_mul_ce (
    .clk(clk), .en(en), .a($signed(s3_r.c)), .b($signed(s3_r.e)), .p(p_ce)
  );

  always_comb begin
    s4_nxt      = s3_r;
    s4_nxt.adeg = ($signed(s3_r.bb) <= $signed(DOT_W'(thr_r)));
    s4_nxt.bdeg = ($signed(s3_r.e) <= $signed(DOT_W'(thr_r)));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_r <= s4_nxt;
      s5_r <= s4_r;
    end
  end

  // Stage 6: denominator and numerator of the unclamped s.
  dot_side_t               s6_r;
  logic signed [NUM1_W-1:0] den6_r, num6_r;
  logic                     den0_r;
  logic signed [NUM1_W-1:0] num1_in;

  always_ff @(posedge clk) begin
    if (en) begin
      s6_r   <= s5_r;
      den6_r <= NUM1_W'(p_bbe) - NUM1_W'(p_dd);
      num6_r <= NUM1_W'(p_df) - NUM1_W'(p_ce);
      den0_r <= (p_bbe == p_dd);
    end
  end

  // Parallel segments take s = 0.
  assign num1_in = den0_r ? '0 : num6_r;

  logic                   v_div1;
  logic [Q_W-1:0]         q1;
  logic [DOT_SIDE_W-1:0]  side1_raw;
  dot_side_t              side1;

  spcp_div_pipe #(.NUM_W(NUM1_W), .SIDE_W(DOT_SIDE_W)) u_div_s (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(v6_r), .in_num(num1_in), .in_den(den6_r), .in_side(s6_r),
    .out_valid(v_div1), .out_quot(q1), .out_side(side1_raw)
  );

  assign side1 = dot_side_t'(side1_raw);

  // Stages 7 and 8: numerator and denominator of t.
  dot_side_t                s7_r, s8_r;
  logic [Q_W-1:0]           s1_7_r, s1_8_r;
  logic signed [TP_W-1:0]   tp7_r;
  logic signed [NUM2_W-1:0] tn8_r, te8_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s7_r   <= side1;
      s1_7_r <= q1;
      tp7_r  <= $signed(side1.d) * $signed({1'b0, q1});
      s8_r   <= s7_r;
      s1_8_r <= s1_7_r;
      tn8_r  <= NUM2_W'(tp7_r) + (NUM2_W'($signed(s7_r.f)) <<< FRAC_BITS);
      te8_r  <= NUM2_W'($signed(s7_r.e)) <<< FRAC_BITS;
    end
  end

  // Stage 9: pick the second ratio; t clamped means s is recomputed.
  logic signed [NUM2_W-1:0] neg_c, d_minus_c, ext_bb, ext_e;
  logic signed [NUM2_W-1:0] num9_nxt, den9_nxt, num9_r, den9_r;
  par_side_t                par9_nxt, par9_r;

  assign ext_bb    = NUM2_W'($signed(s8_r.bb));
  assign ext_e     = NUM2_W'($signed(s8_r.e));
  assign neg_c     = NUM2_W'(0) - NUM2_W'($signed(s8_r.c));
  assign d_minus_c = NUM2_W'($signed(s8_r.d)) - NUM2_W'($signed(s8_r.c));

  always_comb begin
    par9_nxt.g      = s8_r.g;
    par9_nxt.fixed  = '0;
    par9_nxt.q_to_t = 1'b0;
    num9_nxt        = '0;
    den9_nxt        = NUM2_W'(1);
    priority if (s8_r.adeg && s8_r.bdeg) begin
      num9_nxt = '0;
    end else if (s8_r.adeg) begin
      num9_nxt        = NUM2_W'($signed(s8_r.f));
      den9_nxt        = ext_e;
      par9_nxt.q_to_t = 1'b1;
    end else if (s8_r.bdeg) begin
      num9_nxt = neg_c;
      den9_nxt = ext_bb;
    end else if (tn8_r[NUM2_W-1]) begin
      num9_nxt = neg_c;
      den9_nxt = ext_bb;
    end else if (tn8_r > te8_r) begin
      num9_nxt       = d_minus_c;
      den9_nxt       = ext_bb;
      par9_nxt.fixed = Q_ONE;
    end else begin
      num9_nxt        = tn8_r;
      den9_nxt        = te8_r;
      par9_nxt.fixed  = s1_8_r;
      par9_nxt.q_to_t = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num9_r <= num9_nxt;
      den9_r <= den9_nxt;
      par9_r <= par9_nxt;
    end
  end

  logic                   v_div2;
  logic [Q_W-1:0]         q2;
  logic [PAR_SIDE_W-1:0]  side2_raw;
  par_side_t              side2;

  spcp_div_pipe #(.NUM_W(NUM2_W), .SIDE_W(PAR_SIDE_W)) u_div_t (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(v9_r), .in_num(num9_r), .in_den(den9_r), .in_side(par9_r),
    .out_valid(v_div2), .out_quot(q2), .out_side(side2_raw)
  );

  assign side2 = par_side_t'(side2_raw);

  // Stage 10: direction times parameter.
  logic [Q_W-1:0]          s_par, t_par;
  geo_t                    g10_r;
  logic signed [PT_W-1:0]  pa10_r [3];
  logic signed [PT_W-1:0]  pb10_r [3];

  assign s_par = side2.q_to_t ? side2.fixed : q2;
  assign t_par = side2.q_to_t ? q2 : side2.fixed;

  always_ff @(posedge clk) begin
    if (en) begin
      g10_r <= side2.g;
      for (int i = 0; i < 3; i++) begin
        pa10_r[i] <= $signed(side2.g.d1[i]) * $signed({1'b0, s_par});
        pb10_r[i] <= $signed(side2.g.d2[i]) * $signed({1'b0, t_par});
      end
    end
  end

  // Stage 11: floor shift, add start point, saturate.
  logic signed [SUM_W-1:0]       suma [3];
  logic signed [SUM_W-1:0]       sumb [3];
  logic [2:0][COORD_WIDTH-1:0]   na11_nxt, nb11_nxt, na11_r, nb11_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      suma[i] = SUM_W'($signed(pa10_r[i][PT_W-1:FRAC_BITS])) +
                SUM_W'($signed(g10_r.a0[i]));
      sumb[i] = SUM_W'($signed(pb10_r[i][PT_W-1:FRAC_BITS])) +
                SUM_W'($signed(g10_r.b0[i]));
      priority if (suma[i] > SAT_HI) begin
        na11_nxt[i] = SAT_HI[COORD_WIDTH-1:0];
      end else if (suma[i] < SAT_LO) begin
        na11_nxt[i] = SAT_LO[COORD_WIDTH-1:0];
      end else begin
        na11_nxt[i] = suma[i][COORD_WIDTH-1:0];
      end
      priority if (sumb[i] > SAT_HI) begin
        nb11_nxt[i] = SAT_HI[COORD_WIDTH-1:0];
      end else if (sumb[i] < SAT_LO) begin
        nb11_nxt[i] = SAT_LO[COORD_WIDTH-1:0];
      end else begin
        nb11_nxt[i] = sumb[i][COORD_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      na11_r <= na11_nxt;
      nb11_r <= nb11_nxt;
    end
  end

  // Valid bits of the stages owned by this module.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
      v4_r  <= 1'b0;
      v5_r  <= 1'b0;
      v6_r  <= 1'b0;
      v7_r  <= 1'b0;
      v8_r  <= 1'b0;
      v9_r  <= 1'b0;
      v10_r <= 1'b0;
      v11_r <= 1'b0;
    end else if (en) begin
      v1_r  <= in_valid;
      v2_r  <= v1_r;
      v3_r  <= v2_r;
      v4_r  <= v3_r;
      v5_r  <= v4_r;
      v6_r  <= v5_r;
      v7_r  <= v_div1;
      v8_r  <= v7_r;
      v9_r  <= v8_r;
      v10_r <= v_div2;
      v11_r <= v10_r;
    end
  end

  // Output register.
  logic [2:0][COORD_WIDTH-1:0] out_a_r, out_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= v11_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_a_r <= na11_r;
      out_b_r <= nb11_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_near_a_x = out_a_r[0];
  assign out_near_a_y = out_a_r[1];
  assign out_near_a_z = out_a_r[2];
  assign out_near_b_x = out_b_r[0];
  assign out_near_b_y = out_b_r[1];
  assign out_near_b_z = out_b_r[2];

  `SPCP_ASSERT_IMP(a_flow_when_drained, clk, rst_n, !v11_r, !in_stall, "stall with empty last stage")
  `SPCP_ASSERT_NXT(a_freeze_holds_last, clk, rst_n, in_stall, $stable(v11_r), "last stage moved while frozen")
  `SPCP_ASSERT_IMP(a_param_in_range, clk, rst_n, v_div2, (q2 <= Q_ONE), "segment parameter above one")

endmodule

`default_nettype wire
